[rtl/brobs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brobs_pkg
// shared sizes, fixed-point helpers and divider handshake types for the
// bordered rank-one block solver
// ----------------------------------------------------------------------------
package brobs_pkg;

  localparam int DIMS   = 3;
  localparam int BLOCKS = 12;

  localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W  = $clog2(BLOCKS + 1);
  localparam int PROD_W = 48;
  localparam int ACC_W  = 50;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  localparam logic [2:0] CFG_NORMAL_X   = 3'd0;
  localparam logic [2:0] CFG_NORMAL_Y   = 3'd1;
  localparam logic [2:0] CFG_NORMAL_Z   = 3'd2;
  localparam logic [2:0] CFG_DIAG_SHIFT = 3'd3;

  typedef struct packed {
    logic              start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              zero;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(Q_MAX);
    lo = ACC_W'(Q_MIN);
    if (v > hi) return Q_MAX;
    if (v < lo) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qsat(input logic signed [PROD_W-1:0] p);
    return sat_acc(ACC_W'(p));
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat_acc(ACC_W'(a) + ACC_W'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat_acc(ACC_W'(a) - ACC_W'(b));
  endfunction

  // full product, round half up, floor shift by 16
  function automatic logic signed [PROD_W-1:0] mulround(input logic signed [31:0] a,
                                                        input logic signed [31:0] b);
    logic signed [63:0] pr;
    pr = 64'(a) * 64'(b) + 64'sd32768;
    return pr[63:16];
  endfunction

endpackage

[rtl/brobs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brobs_div
// radix-2 restoring divider: (num * 2^16) / den, truncated toward zero and
// saturated to 32 bits; a zero divisor saturates and flags at once
// ----------------------------------------------------------------------------
module brobs_div import brobs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              zero_q, zero_d;
  logic signed [31:0] quo_q, quo_d;
  logic [47:0]       nq_q, nq_d;
  logic [32:0]       rem_q, rem_d;
  logic [31:0]       dv_q, dv_d;
  logic              neg_q, neg_d;
  logic [5:0]        cnt_q, cnt_d;

  logic [31:0] num_abs;
  logic [31:0] den_abs;
  logic [32:0] rem_sh;
  logic        fits;
  logic [47:0] nq_nx;

  always_comb begin
    num_abs = req_i.num[31] ? (~req_i.num + 32'd1) : req_i.num;
    den_abs = req_i.den[31] ? (~req_i.den + 32'd1) : req_i.den;
    rem_sh  = {rem_q[31:0], nq_q[47]};
    fits    = rem_sh >= {1'b0, dv_q};
    nq_nx   = {nq_q[46:0], fits};

    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    quo_d  = quo_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;

    if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dv_q}) : rem_sh;
      nq_d  = nq_nx;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) begin
          quo_d = (nq_nx > 48'h0000_8000_0000) ? Q_MIN : (~nq_nx[31:0] + 32'd1);
        end else begin
          quo_d = (nq_nx > 48'h0000_7fff_ffff) ? Q_MAX : nq_nx[31:0];
        end
      end
    end else if (req_i.start) begin
      if (req_i.den == 32'sd0) begin
        done_d = 1'b1;
        zero_d = 1'b1;
        quo_d  = req_i.num[31] ? Q_MIN : Q_MAX;
      end else begin
        busy_d = 1'b1;
        zero_d = 1'b0;
        nq_d   = {num_abs, 16'h0000};
        rem_d  = '0;
        dv_d   = den_abs;
        neg_d  = req_i.num[31] ^ req_i.den[31];
        cnt_d  = 6'd47;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    quo_q  <= quo_d;
    nq_q   <= nq_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    neg_q  <= neg_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.zero = zero_q;
  assign rsp_o.quo  = quo_q;

endmodule

[rtl/bordered_rank_one_block_solver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bordered_rank_one_block_solver_top
// solves the shifted arrowhead system with Sherman-Morrison block inverses
// and a Schur complement for the corner unknown, Q16.16 throughout
// ----------------------------------------------------------------------------
// usage:
//  - write normal_x/y/z and diag_shift on the cfg channel while idle
//  - send one beat per block on the slave stream (tuser low); each is taken
//    while the solver is idle and stored in the block memory; beats past BLOCKS drop
//  - a beat with tuser high carries the corner terms and starts the solve;
//    tready stays low until the last result is in the output register
//  - the solve opens with a normal length product; the first sweep over the
//    stored blocks waits on two divider results per block and on the shared
//    multiplier; the corner division follows; the second sweep reads the
//    stored inverse coefficients from the coefficient memory
//  - results leave on the master stream: one beat per block, then the
//    corner beat with tlast high; tuser flags a zero divisor in the solve
//  - a stalled receiver holds the sequencer in its output wait; the output
//    register frees as soon as the beat is taken
//  - reset empties the block count and the output register
// ----------------------------------------------------------------------------
module bordered_rank_one_block_solver_top import brobs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [159:0] s_axis_tdata_i,  // ident_coef, outer_coef, rhs_x, rhs_y, rhs_z
  input  logic         s_axis_tuser_i,  // is_border
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,  // sol_x, sol_y, sol_z, block_index, zero pad
  output logic         m_axis_tlast_o,  // last_result
  output logic         m_axis_tuser_o   // div_error
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_D0    = 6'd1;
  localparam logic [5:0] S_D1    = 6'd2;
  localparam logic [5:0] S_D2    = 6'd3;
  localparam logic [5:0] S_D3    = 6'd4;
  localparam logic [5:0] S_C0    = 6'd5;
  localparam logic [5:0] S_C1    = 6'd6;
  localparam logic [5:0] S_V0    = 6'd7;
  localparam logic [5:0] S_V1    = 6'd8;
  localparam logic [5:0] S_V2    = 6'd9;
  localparam logic [5:0] S_V3    = 6'd10;
  localparam logic [5:0] S_V4    = 6'd11;
  localparam logic [5:0] S_V5    = 6'd12;
  localparam logic [5:0] S_P1RD  = 6'd13;
  localparam logic [5:0] S_P1LD  = 6'd14;
  localparam logic [5:0] S_P1W1  = 6'd15;
  localparam logic [5:0] S_P12   = 6'd16;
  localparam logic [5:0] S_P13   = 6'd17;
  localparam logic [5:0] S_P14   = 6'd18;
  localparam logic [5:0] S_P15   = 6'd19;
  localparam logic [5:0] S_P1W2  = 6'd20;
  localparam logic [5:0] S_A0    = 6'd21;
  localparam logic [5:0] S_A1    = 6'd22;
  localparam logic [5:0] S_A2    = 6'd23;
  localparam logic [5:0] S_A3    = 6'd24;
  localparam logic [5:0] S_G0    = 6'd25;
  localparam logic [5:0] S_G1    = 6'd26;
  localparam logic [5:0] S_CN    = 6'd27;
  localparam logic [5:0] S_CW    = 6'd28;
  localparam logic [5:0] S_P3RD  = 6'd29;
  localparam logic [5:0] S_P3LD  = 6'd30;
  localparam logic [5:0] S_P31   = 6'd31;
  localparam logic [5:0] S_P32   = 6'd32;
  localparam logic [5:0] S_P33   = 6'd33;
  localparam logic [5:0] S_P34   = 6'd34;
  localparam logic [5:0] S_P35   = 6'd35;
  localparam logic [5:0] S_OUT   = 6'd36;
  localparam logic [5:0] S_OUTC  = 6'd37;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_NRM  = 2'd1;
  localparam logic [1:0] PH_RHS  = 2'd2;
  localparam logic [1:0] PH_SOL  = 2'd3;

  logic [5:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic       inv_q, inv_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] nblk_q, nblk_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic signed [31:0] osum_q, osum_d;
  logic signed [31:0] nx_q, ny_q, nz_q, sh_q;
  logic signed [31:0] nl2_q, nl2_d;
  logic signed [31:0] b_q, b_d, rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic signed [31:0] inva_q, inva_d, invb_q, invb_d;
  logic signed [31:0] bba_q, bba_d, den_q, den_d, t_q, t_d, c_q, c_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic signed [31:0] dot_q, dot_d, ad0_q, ad0_d, gd0_q, gd0_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic       err_q, err_d;
  logic signed [31:0] ma, mb;
  logic signed [PROD_W-1:0] p_q;
  logic signed [31:0] pq;
  logic signed [31:0] dsum;
  logic signed [31:0] nz_eff;

  logic       ov_q, ov_d, olast_q, olast_d, oerr_q, oerr_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [3:0] oidx_q, oidx_d;

  logic [159:0] blk_mem [BLOCKS];
  logic [159:0] blk_rd_q;
  logic [159:0] blk_wdata;
  logic         blk_we;
  logic [63:0]  coef_mem [BLOCKS];
  logic [63:0]  coef_rd_q;
  logic         coef_we;
  logic [IDX_W-1:0] raddr;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic out_free;

  brobs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign nz_eff   = (DIMS > 2) ? nz_q : 32'sd0;
  assign pq       = qsat(p_q);
  assign dsum     = sat_acc(acc_q + ACC_W'(p_q));
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ov_q || m_axis_tready_i;
  assign raddr    = i_q[IDX_W-1:0];

  assign s_axis_tready_o = (st_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    blk_wdata = {((DIMS > 2) ? s_axis_tdata_i[159:128] : 32'd0), s_axis_tdata_i[127:0]};
    blk_we    = in_acc && !s_axis_tuser_i && (cnt_q < CNT_W'(BLOCKS));
  end

  always_comb begin
    st_d = st_q;  ph_d = ph_q;  inv_d = inv_q;
    cnt_d = cnt_q;  nblk_d = nblk_q;  i_d = i_q;  osum_d = osum_q;
    nl2_d = nl2_q;  b_d = b_q;  rx_d = rx_q;  ry_d = ry_q;  rz_d = rz_q;
    inva_d = inva_q;  invb_d = invb_q;  bba_d = bba_q;  den_d = den_q;
    t_d = t_q;  c_d = c_q;  vx_d = vx_q;  vy_d = vy_q;  vz_d = vz_q;
    dot_d = dot_q;  acc_d = acc_q;  ad0_d = ad0_q;  gd0_d = gd0_q;  err_d = err_q;
    ov_d = ov_q;  olast_d = olast_q;  oerr_d = oerr_q;
    ox_d = ox_q;  oy_d = oy_q;  oz_d = oz_q;  oidx_d = oidx_q;
    ma = 32'sd0;  mb = 32'sd0;
    div_req.start = 1'b0;
    div_req.num   = 32'sd0;
    div_req.den   = 32'sd0;
    coef_we = 1'b0;

    if (ov_q && m_axis_tready_i) ov_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            ad0_d  = qadd(s_axis_tdata_i[31:0], osum_q);
            gd0_d  = s_axis_tdata_i[95:64];
            err_d  = 1'b0;
            nblk_d = cnt_q;
            cnt_d  = '0;
            osum_d = 32'sd0;
            vx_d   = nx_q;
            vy_d   = ny_q;
            vz_d   = nz_eff;
            ph_d   = PH_LEN;
            inv_d  = 1'b0;
            st_d   = S_D0;
          end else if (blk_we) begin
            osum_d = qadd(osum_q, s_axis_tdata_i[63:32]);
            cnt_d  = cnt_q + CNT_W'(1);
          end
        end
      end
      S_D0: begin
        ma = nx_q;  mb = vx_q;  st_d = S_D1;
      end
      S_D1: begin
        acc_d = ACC_W'(p_q);  ma = ny_q;  mb = vy_q;  st_d = S_D2;
      end
      S_D2: begin
        acc_d = acc_q + ACC_W'(p_q);  ma = nz_eff;  mb = vz_q;  st_d = S_D3;
      end
      S_D3: begin
        dot_d = dsum;
        if (inv_q) begin
          st_d = S_C0;
        end else begin
          unique case (ph_q)
            PH_LEN: begin
              nl2_d = dsum;
              i_d   = '0;
              st_d  = (nblk_q == '0) ? S_CN : S_P1RD;
            end
            PH_NRM:  st_d = S_A0;
            PH_RHS:  st_d = S_G0;
            default: st_d = S_OUT;
          endcase
        end
      end
      S_C0: begin
        ma = dot_q;  mb = invb_q;  st_d = S_C1;
      end
      S_C1: begin
        c_d = pq;  ma = inva_q;  mb = vx_q;  st_d = S_V0;
      end
      S_V0: begin
        t_d = pq;  ma = nx_q;  mb = c_q;  st_d = S_V1;
      end
      S_V1: begin
        vx_d = qadd(t_q, pq);  ma = inva_q;  mb = vy_q;  st_d = S_V2;
      end
      S_V2: begin
        t_d = pq;  ma = ny_q;  mb = c_q;  st_d = S_V3;
      end
      S_V3: begin
        vy_d = qadd(t_q, pq);  ma = inva_q;  mb = vz_q;  st_d = S_V4;
      end
      S_V4: begin
        t_d = pq;  ma = nz_eff;  mb = c_q;  st_d = S_V5;
      end
      S_V5: begin
        vz_d  = qadd(t_q, pq);
        inv_d = 1'b0;
        st_d  = (ph_q == PH_SOL) ? S_OUT : S_D0;
      end
      S_P1RD: st_d = S_P1LD;
      S_P1LD: begin
        b_d  = blk_rd_q[63:32];
        rx_d = blk_rd_q[95:64];
        ry_d = blk_rd_q[127:96];
        rz_d = blk_rd_q[159:128];
        div_req.start = 1'b1;
        div_req.num   = Q_ONE;
        div_req.den   = qadd(blk_rd_q[31:0], sh_q);
        st_d = S_P1W1;
      end
      S_P1W1: begin
        if (div_rsp.done) begin
          inva_d = div_rsp.quo;
          err_d  = err_q | div_rsp.zero;
          ma = b_q;  mb = div_rsp.quo;
          st_d = S_P12;
        end
      end
      S_P12: begin
        bba_d = pq;  st_d = S_P13;
      end
      S_P13: begin
        ma = nl2_q;  mb = bba_q;  st_d = S_P14;
      end
      S_P14: begin
        den_d = qadd(Q_ONE, pq);  ma = bba_q;  mb = inva_q;  st_d = S_P15;
      end
      S_P15: begin
        div_req.start = 1'b1;
        div_req.num   = qsub(32'sd0, pq);
        div_req.den   = den_q;
        st_d = S_P1W2;
      end
      S_P1W2: begin
        if (div_rsp.done) begin
          invb_d  = div_rsp.quo;
          err_d   = err_q | div_rsp.zero;
          coef_we = 1'b1;
          vx_d = nx_q;  vy_d = ny_q;  vz_d = nz_eff;
          ph_d = PH_NRM;  inv_d = 1'b1;
          st_d = S_D0;
        end
      end
      S_A0: begin
        ma = b_q;  mb = b_q;  st_d = S_A1;
      end
      S_A1: begin
        t_d = pq;  st_d = S_A2;
      end
      S_A2: begin
        ma = dot_q;  mb = t_q;  st_d = S_A3;
      end
      S_A3: begin
        ad0_d = qsub(ad0_q, pq);
        vx_d = rx_q;  vy_d = ry_q;  vz_d = rz_q;
        ph_d = PH_RHS;  inv_d = 1'b1;
        st_d = S_D0;
      end
      S_G0: begin
        ma = dot_q;  mb = b_q;  st_d = S_G1;
      end
      S_G1: begin
        gd0_d = qsub(gd0_q, pq);
        i_d   = i_q + CNT_W'(1);
        st_d  = ((i_q + CNT_W'(1)) == nblk_q) ? S_CN : S_P1RD;
      end
      S_CN: begin
        div_req.start = 1'b1;
        div_req.num   = gd0_q;
        div_req.den   = qadd(ad0_q, sh_q);
        st_d = S_CW;
      end
      S_CW: begin
        if (div_rsp.done) begin
          gd0_d = div_rsp.quo;
          err_d = err_q | div_rsp.zero;
          i_d   = '0;
          st_d  = (nblk_q == '0) ? S_OUTC : S_P3RD;
        end
      end
      S_P3RD: st_d = S_P3LD;
      S_P3LD: begin
        b_d    = blk_rd_q[63:32];
        rx_d   = blk_rd_q[95:64];
        ry_d   = blk_rd_q[127:96];
        rz_d   = blk_rd_q[159:128];
        inva_d = coef_rd_q[31:0];
        invb_d = coef_rd_q[63:32];
        ma = gd0_q;  mb = blk_rd_q[63:32];
        st_d = S_P31;
      end
      S_P31: begin
        c_d = pq;  st_d = S_P32;
      end
      S_P32: begin
        ma = nx_q;  mb = c_q;  st_d = S_P33;
      end
      S_P33: begin
        vx_d = qsub(rx_q, pq);  ma = ny_q;  mb = c_q;  st_d = S_P34;
      end
      S_P34: begin
        vy_d = qsub(ry_q, pq);  ma = nz_eff;  mb = c_q;  st_d = S_P35;
      end
      S_P35: begin
        vz_d = qsub(rz_q, pq);
        ph_d = PH_SOL;  inv_d = 1'b1;
        st_d = S_D0;
      end
      S_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;  olast_d = 1'b0;  oerr_d = err_q;
          ox_d = vx_q;  oy_d = vy_q;  oz_d = vz_q;
          oidx_d = 4'(i_q);
          i_d  = i_q + CNT_W'(1);
          st_d = ((i_q + CNT_W'(1)) == nblk_q) ? S_OUTC : S_P3RD;
        end
      end
      S_OUTC: begin
        if (out_free) begin
          ov_d = 1'b1;  olast_d = 1'b1;  oerr_d = err_q;
          ox_d = gd0_q;  oy_d = 32'sd0;  oz_d = 32'sd0;
          oidx_d = 4'(BLOCKS);
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ph_q   <= PH_LEN;
      inv_q  <= 1'b0;
      cnt_q  <= '0;
      nblk_q <= '0;
      i_q    <= '0;
      osum_q <= 32'sd0;
      ov_q   <= 1'b0;
      nx_q   <= 32'sd0;
      ny_q   <= 32'sd0;
      nz_q   <= 32'sd0;
      sh_q   <= 32'sd0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      inv_q  <= inv_d;
      cnt_q  <= cnt_d;
      nblk_q <= nblk_d;
      i_q    <= i_d;
      osum_q <= osum_d;
      ov_q   <= ov_d;
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          CFG_NORMAL_X:   nx_q <= cfg_data_i;
          CFG_NORMAL_Y:   ny_q <= cfg_data_i;
          CFG_NORMAL_Z:   nz_q <= cfg_data_i;
          CFG_DIAG_SHIFT: sh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= mulround(ma, mb);
    nl2_q  <= nl2_d;   b_q    <= b_d;     rx_q  <= rx_d;   ry_q <= ry_d;  rz_q <= rz_d;
    inva_q <= inva_d;  invb_q <= invb_d;  bba_q <= bba_d;  den_q <= den_d;
    t_q    <= t_d;     c_q    <= c_d;     vx_q  <= vx_d;   vy_q <= vy_d;  vz_q <= vz_d;
    dot_q  <= dot_d;   acc_q  <= acc_d;   ad0_q <= ad0_d;  gd0_q <= gd0_d;
    err_q  <= err_d;
    olast_q <= olast_d;  oerr_q <= oerr_d;
    ox_q <= ox_d;  oy_q <= oy_d;  oz_q <= oz_d;  oidx_q <= oidx_d;
  end

  // block store and per-block inverse coefficients
  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[cnt_q[IDX_W-1:0]] <= blk_wdata;
    blk_rd_q <= blk_mem[raddr];
    if (coef_we) coef_mem[raddr] <= {invb_d, inva_q};
    coef_rd_q <= coef_mem[raddr];
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {4'h0, oidx_q, oz_q, oy_q, ox_q};
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = oerr_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(BLOCKS))
    else $error("block count above depth");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (oidx_q == 4'(BLOCKS)))
    else $error("last beat is not the corner result");

  a_busy_no_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |=> $stable(cnt_q))
    else $error("block count moved during solve");
`endif

endmodule

[verif/bordered_rank_one_block_solver_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bordered_rank_one_block_solver_top_tb
// drives block and border beats through the solver under several normal and
// shift settings, predicts every solved block vector and corner unknown in
// Q16.16, and checks each result beat field by field with random stalls
// ----------------------------------------------------------------------------
module bordered_rank_one_block_solver_top_tb;
  import brobs_pkg::*;

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  RAND_ITEMS  = 450;
  localparam int  LONG_HOLD   = 3000;

  typedef struct {
    bit border;
    int ident;
    int outer;
    int rx;
    int ry;
    int rz;
  } sys_beat_t;

  typedef struct {
    int       x;
    int       y;
    int       z;
    bit [3:0] idx;
    bit       last;
    bit       err;
  } sol_beat_t;

  typedef struct {
    sys_beat_t b;
    bit        typed;
    int        tx;
    bit        terr;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [103:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         m_axis_tuser_o;

  bordered_rank_one_block_solver_top uut (.*);

  always #2 clk_i = ~clk_i;

  // solver state mirror
  int        nrm [3];
  int        shift_q;
  int        id_mem [BLOCKS];
  int        ou_mem [BLOCKS];
  int        rhs_mem [BLOCKS*3];
  int        nblk;
  int        osum;
  bit        zdiv;
  sol_beat_t sol_q [$];

  int  failures;
  int  n_beats;
  int  n_solves;
  int  n_checked;
  int  cycles;
  bit  quiet;
  bit  hold_req;
  bit  hold_done;
  int  hold_left;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint mul_rnd(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic int fx_mul(int a, int b);
    return sat32(mul_rnd(a, b));
  endfunction

  function automatic int fx_add(int a, int b);
    return sat32(longint'(a) + longint'(b));
  endfunction

  function automatic int fx_sub(int a, int b);
    return sat32(longint'(a) - longint'(b));
  endfunction

  function automatic int fx_div(int a, int b);
    if (b == 0) begin
      zdiv = 1'b1;
      return (a >= 0) ? 32'sh7fffffff : 32'sh80000000;
    end
    return sat32((longint'(a) * 64'sd65536) / longint'(b));
  endfunction

  function automatic int fx_dot(int u [3], int v [3]);
    longint acc;
    acc = 0;
    for (int j = 0; j < DIMS; j++) acc += mul_rnd(u[j], v[j]);
    return sat32(acc);
  endfunction

  // sherman-morrison inverse of (a+shift)I + b n n^T applied to v
  function automatic void sm_apply(int a, int b, int nv [3], int nlen2, inout int v [3]);
    int inv_a, b_by_a, den, inv_b, c;
    inv_a  = fx_div(Q_ONE, fx_add(a, shift_q));
    b_by_a = fx_mul(b, inv_a);
    den    = fx_add(Q_ONE, fx_mul(nlen2, b_by_a));
    inv_b  = fx_div(fx_sub(0, fx_mul(b_by_a, inv_a)), den);
    c      = fx_mul(fx_dot(nv, v), inv_b);
    for (int j = 0; j < DIMS; j++) v[j] = fx_add(fx_mul(inv_a, v[j]), fx_mul(nv[j], c));
  endfunction

  // returns 1 if the beat is stored or starts a solve
  function automatic bit solve_predict(sys_beat_t b);
    int nv [3];
    int tmp [3];
    int sols [BLOCKS][3];
    int nlen2, ad0, gd0, c;
    sol_beat_t r;
    if (!b.border) begin
      if (nblk >= BLOCKS) return 1'b0;
      id_mem[nblk] = b.ident;
      ou_mem[nblk] = b.outer;
      rhs_mem[nblk*3]   = b.rx;
      rhs_mem[nblk*3+1] = b.ry;
      rhs_mem[nblk*3+2] = (DIMS > 2) ? b.rz : 0;
      osum = fx_add(osum, b.outer);
      nblk++;
      return 1'b1;
    end
    zdiv = 1'b0;
    nv[0] = nrm[0];
    nv[1] = nrm[1];
    nv[2] = (DIMS > 2) ? nrm[2] : 0;
    nlen2 = fx_dot(nv, nv);
    ad0 = fx_add(b.ident, osum);
    gd0 = b.rx;
    for (int i = 0; i < nblk; i++) begin
      tmp = nv;
      sm_apply(id_mem[i], ou_mem[i], nv, nlen2, tmp);
      ad0 = fx_sub(ad0, fx_mul(fx_dot(tmp, nv), fx_mul(ou_mem[i], ou_mem[i])));
      for (int j = 0; j < 3; j++) tmp[j] = rhs_mem[i*3+j];
      sm_apply(id_mem[i], ou_mem[i], nv, nlen2, tmp);
      gd0 = fx_sub(gd0, fx_mul(fx_dot(tmp, nv), ou_mem[i]));
    end
    gd0 = fx_div(gd0, fx_add(ad0, shift_q));
    for (int i = 0; i < nblk; i++) begin
      c = fx_mul(gd0, ou_mem[i]);
      for (int j = 0; j < 3; j++) sols[i][j] = 0;
      for (int j = 0; j < DIMS; j++) sols[i][j] = fx_sub(rhs_mem[i*3+j], fx_mul(nv[j], c));
      tmp = sols[i];
      sm_apply(id_mem[i], ou_mem[i], nv, nlen2, tmp);
      sols[i] = tmp;
    end
    for (int i = 0; i < nblk; i++) begin
      r = '{sols[i][0], sols[i][1], sols[i][2], 4'(i), 1'b0, zdiv};
      sol_q.push_back(r);
    end
    r = '{gd0, 0, 0, 4'(BLOCKS), 1'b1, zdiv};
    sol_q.push_back(r);
    nblk = 0;
    osum = 0;
    n_solves++;
    return 1'b1;
  endfunction

  function automatic int rand_q();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return int'($urandom);
    if (sel == 1) begin
      case ($urandom_range(3))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return 0;
        default: return Q_ONE;
      endcase
    end
    return int'($urandom_range(524288)) - 262144;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(sys_beat_t b, output bit stored);
    if (!quiet && $urandom_range(99) < 21) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= b.border;
    s_axis_tdata_i  <= {b.rz, b.ry, b.rx, b.outer, b.ident};
    do @(posedge clk_i); while (!s_axis_tready_o);
    stored = solve_predict(b);
    n_beats++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_pause();
    s_axis_tvalid_i <= 1'b0;
    while (sol_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // called at a falling edge, leaves valid high for the next write
  task automatic cfg_write(logic [2:0] addr, int val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      CFG_NORMAL_X:   nrm[0]  = val;
      CFG_NORMAL_Y:   nrm[1]  = val;
      CFG_NORMAL_Z:   nrm[2]  = val;
      CFG_DIAG_SHIFT: shift_q = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic cfg_all(int nx, int ny, int nz, int sh);
    cfg_write(CFG_NORMAL_X, nx);
    cfg_write(CFG_NORMAL_Y, ny);
    cfg_write(CFG_NORMAL_Z, nz);
    cfg_write(CFG_DIAG_SHIFT, sh);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver ready with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (quiet) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    sol_beat_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (sol_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        failures++;
      end else begin
        e = sol_q.pop_front();
        n_checked++;
        if (m_axis_tdata_o[31:0] !== e.x) begin
          $error("sol_x mismatch: expected %0d, got %0d", e.x, $signed(m_axis_tdata_o[31:0]));
          failures++;
        end
        if (m_axis_tdata_o[63:32] !== e.y) begin
          $error("sol_y mismatch: expected %0d, got %0d", e.y, $signed(m_axis_tdata_o[63:32]));
          failures++;
        end
        if (m_axis_tdata_o[95:64] !== e.z) begin
          $error("sol_z mismatch: expected %0d, got %0d", e.z, $signed(m_axis_tdata_o[95:64]));
          failures++;
        end
        if (m_axis_tdata_o[99:96] !== e.idx) begin
          $error("block_index mismatch: expected %0d, got %0d", e.idx, m_axis_tdata_o[99:96]);
          failures++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last_result mismatch: expected %0d, got %0d", e.last, m_axis_tlast_o);
          failures++;
        end
        if (m_axis_tuser_o !== e.err) begin
          $error("div_error mismatch: expected %0d, got %0d", e.err, m_axis_tuser_o);
          failures++;
        end
      end
    end
  end

  initial begin
    dir_row_t  rows [$];
    sys_beat_t b;
    sol_beat_t t;
    bit        stored;
    int        done_items;
    int        k;
    int        sel;
    nrm = '{0, 0, 0};
    shift_q = 0;
    nblk = 0;
    osum = 0;
    // zero divisor with positive and negative corner, plain corner divide
    rows.push_back('{'{1, 0, 0, 7 * Q_ONE, 0, 0}, 1, Q_MAX, 1});
    rows.push_back('{'{1, 0, 0, Q_MIN, 0, 0}, 1, Q_MIN, 1});
    rows.push_back('{'{1, Q_ONE, 0, 3 * Q_ONE, 0, 0}, 1, 3 * Q_ONE, 0});
    // field extremes
    rows.push_back('{'{0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX}, 0, 0, 0});
    rows.push_back('{'{0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN}, 0, 0, 0});
    rows.push_back('{'{0, 0, 0, 0, 0, -1}, 0, 0, 0});
    rows.push_back('{'{1, Q_MAX, -1, Q_MAX, -1, -1}, 0, 0, 0});
    rows.push_back('{'{0, 2 * Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE}, 0, 0, 0});
    rows.push_back('{'{1, Q_ONE, 0, Q_ONE, 0, 0}, 0, 0, 0});
    // one block past the store size is dropped
    for (int i = 0; i <= BLOCKS; i++)
      rows.push_back('{'{0, (i + 1) * Q_ONE, i * 8192, i * Q_ONE, -i * Q_ONE, Q_ONE}, 0, 0, 0});
    rows.push_back('{'{1, 2 * Q_ONE, 0, -Q_ONE, 0, 0}, 0, 0, 0});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    foreach (rows[r]) begin
      send_beat(rows[r].b, stored);
      if (rows[r].typed) begin
        t = sol_q.pop_back();
        t.x = rows[r].tx;
        t.err = rows[r].terr;
        sol_q.push_back(t);
      end
    end
    drain_and_pause();

    done_items = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cfg_all(Q_ONE, 0, 0, 0);
        1: cfg_all(rand_q(), rand_q(), rand_q(), rand_q());
        2: cfg_all(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        3: cfg_all(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        4: cfg_all(int'($urandom_range(131072)) - 65536, int'($urandom_range(131072)) - 65536,
                   int'($urandom_range(131072)) - 65536, int'($urandom_range(65536)));
        default: cfg_all(0, Q_ONE / 2, -Q_ONE / 2, Q_ONE);
      endcase
      quiet = (ph == 4);
      if (ph == 1) hold_req = 1'b1;
      while (done_items < (ph + 1) * RAND_ITEMS / 6) begin
        sel = $urandom_range(19);
        if (sel < 15) k = $urandom_range(0, 4);
        else if (sel < 18) k = BLOCKS;
        else k = BLOCKS + $urandom_range(1, 3);
        for (int i = 0; i < k; i++) begin
          b = '{0, rand_q(), rand_q(), rand_q(), rand_q(), rand_q()};
          send_beat(b, stored);
          if (stored) done_items++;
        end
        b = '{1, rand_q(), rand_q(), rand_q(), rand_q(), rand_q()};
        send_beat(b, stored);
        done_items++;
      end
      quiet = 1'b0;
      drain_and_pause();
    end

    $display("sent %0d input beats over six settings, %0d solves", n_beats, n_solves);
    $display("checked %0d result beats, %0d mismatches", n_checked, failures);
    if (failures == 0 && sol_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/brobs_pkg.sv
rtl/brobs_div.sv
rtl/bordered_rank_one_block_solver_top.sv
verif/bordered_rank_one_block_solver_top_tb.sv
